@@ design/cwu_pkg.sv @@
// cwu_pkg: shared widths, register indexes, status codes and the
// controller/datapath command and status structs for the unranking block
// no dependencies
package cwu_pkg;

    localparam int unsigned DEF_MAX_CODE_BITS = 67;

    localparam int unsigned RANK_W    = 64;
    localparam int unsigned CODE_W    = 67;
    localparam int unsigned LOW_W     = 64;
    localparam int unsigned HIGH_W    = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_W     = 7;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] LEN_RST    = 7'd66;
    localparam logic [CFG_W-1:0] WEIGHT_RST = 7'd33;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_WEIGHT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;

    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
        logic chk_stop;
        logic scan_last;
    } t_stat;

endpackage

@@ design/cwu_ctrl.sv @@
// cwu_ctrl: sequencer for table fill, range check and the position scan
// depends on cwu_pkg
module cwu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  cwu_pkg::t_stat i_stat,
    output cwu_pkg::t_cmd  o_cmd,
    output logic          busy
);
    import cwu_pkg::*;

    typedef enum logic [3:0] {
        S_FILL  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.chk_stop) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ design/cwu_dpath.sv @@
// cwu_dpath: configuration registers, binomial table memory with its fill
// sweep, remainder/weight registers and the per-position compare and subtract
// depends on cwu_pkg
module cwu_dpath #(
    parameter int unsigned MAX_CODE_BITS = cwu_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cwu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cwu_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [cwu_pkg::RANK_W-1:0]     i_rank,
    input  cwu_pkg::t_cmd                  i_cmd,
    output cwu_pkg::t_stat                 o_stat,
    output logic                           o_done,
    output logic [cwu_pkg::LOW_W-1:0]      o_code_low,
    output logic [cwu_pkg::HIGH_W-1:0]     o_code_high,
    output logic [cwu_pkg::STATUS_W-1:0]   o_status
);
    import cwu_pkg::*;

    localparam int unsigned TBL_DIM = MAX_CODE_BITS + 1;
    localparam int unsigned DEPTH   = TBL_DIM * TBL_DIM;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned PW      = $clog2(TBL_DIM);
    localparam int unsigned IW      = $clog2(CODE_W);
    localparam logic [AW-1:0] ROW_STEP = AW'(TBL_DIM);
    localparam logic [PW-1:0] MAX_P    = PW'(MAX_CODE_BITS);

    // configuration
    logic [CFG_W-1:0] r_cfg_len;
    logic [CFG_W-1:0] r_cfg_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len    <= LEN_RST;
            r_cfg_weight <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEN:    r_cfg_len    <= i_cfg_data;
                CFG_WEIGHT: r_cfg_weight <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [PW-1:0] len_sat;
    logic [PW-1:0] w_sat;
    logic          bad_w_now;
    logic [AW-1:0] len_base;
    logic [AW-1:0] idle_addr;

    assign len_sat   = (r_cfg_len > CFG_W'(MAX_CODE_BITS)) ? MAX_P : PW'(r_cfg_len);
    assign w_sat     = (r_cfg_weight > CFG_W'(MAX_CODE_BITS)) ? MAX_P : PW'(r_cfg_weight);
    assign bad_w_now = (r_cfg_weight > CFG_W'(len_sat));
    assign len_base  = AW'(AW'(len_sat) * ROW_STEP);
    assign idle_addr = len_base + AW'(w_sat);

    // binomial table
    logic [RANK_W-1:0] r_mem [DEPTH];
    logic [RANK_W-1:0] r_rd_a;
    logic [RANK_W-1:0] r_rd_b;

    // table fill sweep, row by row: C(n,k) = C(n-1,k) + C(n-1,k-1)
    logic          r_fill_issue;
    logic [PW-1:0] r_fn;
    logic [PW-1:0] r_fk;
    logic [AW-1:0] r_fbase;
    logic          r_fw_vld;
    logic          r_fw_last;
    logic [AW-1:0] r_fw_addr;
    logic          r_fw_row0;
    logic          r_fw_k0;
    logic [RANK_W-1:0] r_fprev;
    logic          fill_last;
    logic [AW-1:0] fill_addr;
    logic [RANK_W-1:0] fill_wdata;

    assign fill_last = (r_fn == MAX_P) && (r_fk == MAX_P);
    assign fill_addr = (r_fn == '0) ? '0 : r_fbase - ROW_STEP + AW'(r_fk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_issue <= 1'b1;
            r_fn         <= '0;
            r_fk         <= '0;
            r_fbase      <= '0;
            r_fw_vld     <= 1'b0;
            r_fw_last    <= 1'b0;
        end else begin
            r_fw_vld  <= r_fill_issue;
            r_fw_last <= r_fill_issue && fill_last;
            if (r_fill_issue) begin
                if (fill_last) begin
                    r_fill_issue <= 1'b0;
                end
                if (r_fk == MAX_P) begin
                    r_fk    <= '0;
                    r_fn    <= r_fn + 1'b1;
                    r_fbase <= r_fbase + ROW_STEP;
                end else begin
                    r_fk <= r_fk + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= r_fbase + AW'(r_fk);
        r_fw_row0 <= (r_fn == '0);
        r_fw_k0   <= (r_fk == '0);
        if (r_fw_vld) begin
            r_fprev <= r_rd_a;
        end
    end

    always_comb begin
        if (r_fw_row0) begin
            fill_wdata = r_fw_k0 ? RANK_W'(1) : '0;
        end else begin
            fill_wdata = r_rd_a + (r_fw_k0 ? '0 : r_fprev);
        end
    end

    // scan registers
    logic [RANK_W-1:0] r_rem;
    logic [PW-1:0]     r_left;
    logic [PW-1:0]     r_pos;
    logic [AW-1:0]     r_base;
    logic [CODE_W-1:0] r_code;
    logic              r_sel;
    logic              r_bad_w;

    logic [AW-1:0]     row_next;
    logic [PW-1:0]     left_dn;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic [RANK_W-1:0] cand;
    logic              hit;
    logic [IW-1:0]     pos_idx;
    logic [CODE_W-1:0] n_code;
    logic [RANK_W-1:0] n_rem;
    logic [PW-1:0]     n_left;
    logic [STATUS_W-1:0] chk_status;

    always_ff @(posedge i_clk) begin
        if (r_fw_vld) begin
            r_mem[r_fw_addr] <= fill_wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    assign row_next = (r_base >= ROW_STEP) ? r_base - ROW_STEP : '0;
    assign left_dn  = (r_left == '0) ? '0 : r_left - 1'b1;

    always_comb begin
        if (r_fill_issue) begin
            addr_a = fill_addr;
        end else if (i_cmd.check || i_cmd.scan) begin
            addr_a = row_next + AW'(r_left);
        end else begin
            addr_a = idle_addr;
        end
    end
    assign addr_b = row_next + AW'(left_dn);

    assign cand    = r_sel ? r_rd_b : r_rd_a;
    assign hit     = (r_left != '0) && (r_rem >= cand);
    assign pos_idx = IW'(r_pos - 1'b1);
    assign n_rem   = hit ? r_rem - cand : r_rem;
    assign n_left  = hit ? r_left - 1'b1 : r_left;

    always_comb begin
        n_code = r_code;
        if (hit) begin
            n_code[pos_idx] = 1'b1;
        end
    end

    always_comb begin
        if (r_bad_w) begin
            chk_status = ST_BAD_WEIGHT;
        end else if (r_rem >= r_rd_a) begin
            chk_status = ST_RANGE;
        end else begin
            chk_status = ST_OK;
        end
    end

    assign o_stat.fill_done = r_fw_vld && r_fw_last;
    assign o_stat.chk_stop  = (chk_status != ST_OK) || (r_pos == '0);
    assign o_stat.scan_last = (r_pos == PW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= i_rank;
            r_left  <= w_sat;
            r_pos   <= len_sat;
            r_base  <= len_base;
            r_code  <= '0;
            r_bad_w <= bad_w_now;
        end else if (i_cmd.check) begin
            r_base <= row_next;
            r_sel  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rem  <= n_rem;
            r_left <= n_left;
            r_code <= n_code;
            r_pos  <= r_pos - 1'b1;
            r_base <= row_next;
            r_sel  <= hit;
        end
    end

    // result word
    logic                r_done;
    logic [CODE_W-1:0]   r_out_code;
    logic [STATUS_W-1:0] r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= i_cmd.check ? chk_status : ST_OK;
            r_out_code   <= i_cmd.check ? '0 : n_code;
        end
    end

    assign o_done      = r_done;
    assign o_code_low  = r_out_code[LOW_W-1:0];
    assign o_code_high = r_out_code[CODE_W-1:LOW_W];
    assign o_status    = r_out_status;

endmodule

@@ design/constant_weight_code_unrank.sv @@
// constant_weight_code_unrank: top level, maps a 64-bit rank to its
// constant-weight codeword; instantiates cwu_ctrl and cwu_dpath, uses cwu_pkg
//
//  channel   handshake            payload
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//  input     start, busy          i_rank
//  result    o_done (strobe)      o_code_low, o_code_high, o_status
//
// a rejected word, or one whose saturated code length is 0, ends after the range
// check with no scan;
// the scan does one compare and subtract per position, fed by a two-port table read
// after reset the binomial table is filled with busy high; configuration writes
// are taken throughout
// a new word is accepted in the cycle its predecessor's result is shown
module constant_weight_code_unrank #(
    parameter int unsigned MAX_CODE_BITS = cwu_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cwu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cwu_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [cwu_pkg::RANK_W-1:0]     i_rank,
    output logic                           o_done,
    output logic [cwu_pkg::LOW_W-1:0]      o_code_low,
    output logic [cwu_pkg::HIGH_W-1:0]     o_code_high,
    output logic [cwu_pkg::STATUS_W-1:0]   o_status
);
    import cwu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cwu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    cwu_dpath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rank      (i_rank),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_code_low  (o_code_low),
        .o_code_high (o_code_high),
        .o_status    (o_status)
    );

endmodule

@@ design/cwu_check.sv @@
// cwu_check: port-level assertions for constant_weight_code_unrank
// bound to the top level below; depends on cwu_pkg
module cwu_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [cwu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [cwu_pkg::CFG_W-1:0]      i_cfg_data,
    input logic                           start,
    input logic                           busy,
    input logic [cwu_pkg::RANK_W-1:0]     i_rank,
    input logic                           o_done,
    input logic [cwu_pkg::LOW_W-1:0]      o_code_low,
    input logic [cwu_pkg::HIGH_W-1:0]     o_code_high,
    input logic [cwu_pkg::STATUS_W-1:0]   o_status
);
    import cwu_pkg::*;

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting a word");

    // every result follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a word in flight");

    // no two results back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // a rejected word carries an empty codeword
    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_code_low == '0 && o_code_high == '0))
        else $error("rejected word with non-empty codeword");

endmodule

bind constant_weight_code_unrank cwu_check u_cwu_check (.*);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for constant_weight_code_unrank, predicts each codeword
// from its own binomial table and compares every result word; uses cwu_pkg
module tb;
    import cwu_pkg::*;

    localparam int unsigned CAP = DEF_MAX_CODE_BITS;
    // table fill after reset, worst gap and worst scan, with a wide margin
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [LOW_W-1:0]    low;
        logic [HIGH_W-1:0]   high;
        logic [STATUS_W-1:0] st;
    } t_code_word;

    class t_codeword_board;
        longint unsigned pascal [CAP+1][CAP+1];
        logic [CFG_W-1:0] len_reg;
        logic [CFG_W-1:0] wt_reg;
        t_code_word want_words[$];
        int mismatches;

        function new();
            for (int n = 0; n <= CAP; n++) begin
                for (int k = 0; k <= CAP; k++) begin
                    if (k == 0)
                        pascal[n][k] = 1;
                    else if (n == 0)
                        pascal[n][k] = 0;
                    else
                        pascal[n][k] = pascal[n-1][k-1] + pascal[n-1][k];
                end
            end
            len_reg = LEN_RST;
            wt_reg = WEIGHT_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            if (idx == CFG_LEN)
                len_reg = v;
            else if (idx == CFG_WEIGHT)
                wt_reg = v;
        endfunction

        function int unsigned sat_len();
            return (len_reg > CAP) ? CAP : int'(len_reg);
        endfunction

        // number of codewords for the current setting, 0 when weight is too big
        function longint unsigned code_count();
            int unsigned n;
            n = sat_len();
            if (wt_reg > n)
                return 0;
            return pascal[n][wt_reg];
        endfunction

        function t_code_word unrank(logic [RANK_W-1:0] r);
            int unsigned n;
            int unsigned left;
            int i;
            logic [RANK_W-1:0] rem;
            t_code_word w;
            n = sat_len();
            left = wt_reg;
            rem = r;
            w = '0;
            if (left > n) begin
                w.st = ST_BAD_WEIGHT;
            end else if (r >= pascal[n][left]) begin
                w.st = ST_RANGE;
            end else begin
                w.st = ST_OK;
                for (i = int'(n) - 1; i >= 0; i--) begin
                    if (left > 0 && rem >= pascal[i][left]) begin
                        rem -= pascal[i][left];
                        left--;
                        if (i < LOW_W)
                            w.low[i] = 1'b1;
                        else
                            w.high[i-LOW_W] = 1'b1;
                    end
                end
            end
            return w;
        endfunction

        function void note_rank(logic [RANK_W-1:0] r);
            want_words.push_back(unrank(r));
        endfunction

        function int pending();
            return want_words.size();
        endfunction

        function void check_word(logic [LOW_W-1:0] low, logic [HIGH_W-1:0] high,
                                 logic [STATUS_W-1:0] st);
            t_code_word w;
            if (want_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: low %h high %h status %0d", low, high, st);
                return;
            end
            w = want_words.pop_front();
            if (low !== w.low || high !== w.high || st !== w.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected low %h high %h status %0d, got %h %h %0d",
                             w.low, w.high, w.st, low, high, st);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_LEN;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [RANK_W-1:0]    i_rank = '0;
    logic                 o_done;
    logic [LOW_W-1:0]     o_code_low;
    logic [HIGH_W-1:0]    o_code_high;
    logic [STATUS_W-1:0]  o_status;

    t_codeword_board board;
    int stall = 0;

    constant_weight_code_unrank dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_rank      (i_rank),
        .o_done      (o_done),
        .o_code_low  (o_code_low),
        .o_code_high (o_code_high),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            board.check_word(o_code_low, o_code_high, o_status);
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            stall <= 0;
        end else if (stall >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

    task automatic set_config(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] wt);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_LEN;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_idx <= CFG_WEIGHT;
        i_cfg_data <= wt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(CFG_LEN, len);
        board.set_reg(CFG_WEIGHT, wt);
    endtask

    // start stays high on return, the caller lowers it
    task automatic send_rank(input logic [RANK_W-1:0] r);
        start <= 1'b1;
        i_rank <= r;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        board.note_rank(r);
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic probe(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] wt);
        longint unsigned c;
        set_config(len, wt);
        c = board.code_count();
        send_rank('0);
        send_rank(c - 1);
        send_rank(c);
        start <= 1'b0;
        drain();
    endtask

    function automatic logic [RANK_W-1:0] pick_rank(longint unsigned c);
        int unsigned sel;
        logic [RANK_W-1:0] r;
        sel = $urandom_range(0, 99);
        r = {$urandom(), $urandom()};
        if (c == 0 || sel < 10)
            return r;
        if (sel < 17)
            return c;
        if (sel < 25)
            return c - 1;
        if (sel < 30)
            return '0;
        return r % c;
    endfunction

    task automatic run_phase(input int items, input bit quiet);
        int burst;
        int gap;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < items; k++) begin
            send_rank(pick_rank(board.code_count()));
            burst--;
            if (burst == 0 && !quiet) begin
                if ($urandom_range(0, 3) == 0)
                    gap = $urandom_range(1, 75);
                else
                    gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst = $urandom_range(1, 12);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        int sel;
        int unsigned lim;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] wt;
        longint unsigned c;

        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settings out of reset, before any write
        c = board.code_count();
        send_rank('0);
        send_rank(c - 1);
        send_rank(c);
        send_rank('1);
        start <= 1'b0;
        drain();

        probe(7'd67, 7'd33);
        probe(7'd67, 7'd67);
        probe(7'd67, 7'd0);
        probe(7'd0, 7'd0);
        probe(7'd127, 7'd34);
        probe(7'd127, 7'd127);
        probe(7'd5, 7'd6);
        probe(7'd1, 7'd1);

        for (int p = 0; p < 14; p++) begin
            case (p)
                0: begin len = 7'd67; wt = 7'd33; end
                1: begin len = 7'd67; wt = 7'd1; end
                2: begin len = 7'd67; wt = 7'd66; end
                3: begin len = 7'd2; wt = 7'd1; end
                4: begin len = 7'd1; wt = 7'd0; end
                default: begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        len = CFG_W'($urandom_range(68, 127));
                    else if (sel == 1)
                        len = '0;
                    else
                        len = CFG_W'($urandom_range(1, 67));
                    lim = (len > CAP) ? CAP : len;
                    if ($urandom_range(0, 7) == 0)
                        wt = CFG_W'($urandom_range(0, 127));
                    else
                        wt = CFG_W'($urandom_range(0, lim));
                end
            endcase
            set_config(len, wt);
            run_phase(54, (p % 4) == 3);
            drain();
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
